// ----- hdl/lrtps_pkg.sv -----
// Shared types and constants of the lattice run-and-tumble particle step.
// Field widths, operation codes, register indexes, reset values, result packing.
// No dependencies.
package lrtps_pkg;

    localparam int FUNC_W     = 2;
    localparam int PIDX_W     = 12;
    localparam int SX_W       = 6;
    localparam int SY_W       = 5;
    localparam int DIR_W      = 2;
    localparam int DRAW_W     = 16;
    localparam int WIDTH_W    = 7;
    localparam int HEIGHT_W   = 6;
    localparam int OCC_W      = 3;
    localparam int THR_W      = 17;
    localparam int CNT_OUT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_PLACE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    localparam logic [DIR_W-1:0] DIR_PX = 2'd0;
    localparam logic [DIR_W-1:0] DIR_PY = 2'd1;
    localparam logic [DIR_W-1:0] DIR_MX = 2'd2;
    localparam logic [DIR_W-1:0] DIR_MY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd3;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 7'd40;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 6'd20;
    localparam logic [OCC_W-1:0]    RST_OCC    = 3'd3;
    localparam logic [THR_W-1:0]    RST_THR    = 17'd0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PIDX_W-1:0] pidx;
        logic [SX_W-1:0]   sx;
        logic [SY_W-1:0]   sy;
        logic [DIR_W-1:0]  sdir;
        logic [DRAW_W-1:0] draw;
        logic [DIR_W-1:0]  ndir;
    } item_t;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [PIDX_W-1:0]    pidx,
        input logic [SX_W-1:0]      px,
        input logic [SY_W-1:0]      py,
        input logic [DIR_W-1:0]     hd,
        input logic                 mv,
        input logic                 tb,
        input logic [CNT_OUT_W-1:0] cnt,
        input logic                 st
    );
        return {1'b0, st, cnt, tb, mv, hd, py, px, pidx};
    endfunction

endpackage

// ----- hdl/lattice_run_tumble_particle_step.sv -----
// Run-and-tumble lattice gas step engine: site occupancy and particle records in RAM.
// Depends on lrtps_pkg.
//
//  port group   dir  width  contents
//  cfg_*        in   1/2/17 register write: enable, index, data
//  s_axis_*     in   48/2   operation word, tuser = func
//  m_axis_*     out  32     result word
//
// One word is in flight at a time. Update does the particle read, two count reads and
// two count writes on the count RAM, which has one read port and one write port.
// Place and read do one count read; func three, or a bad particle index on place or
// update, goes straight to the result. A coordinate at or above twice the lattice size
// is reduced in the remainder loop. After reset the count RAM is cleared, tready low.
// A pending result does not block accept; a new result waits for the output register.
module lattice_run_tumble_particle_step #(
    parameter int GRID_X        = 64,
    parameter int GRID_Y        = 32,
    parameter int MAX_PARTICLES = 4096,
    parameter int COUNT_BITS    = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lrtps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrtps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // particle_index, site_x, site_y, start_direction, tumble_draw, new_direction, pad
    input  logic [lrtps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [lrtps_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // particle_out, pos_x, pos_y, heading, moved, tumbled, site_count, status, pad
    output logic [lrtps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int NSITES = GRID_X * GRID_Y;
    localparam int SAW    = $clog2(NSITES);
    localparam int PW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int PRW    = XW + YW + lrtps_pkg::DIR_W;
    localparam int XYW    = (XW > YW) ? XW : YW;
    localparam int DW     = ((XYW > lrtps_pkg::WIDTH_W) ? XYW : lrtps_pkg::WIDTH_W) + 1;
    localparam int CW     = $clog2(DW + 1);
    localparam int CMAX   = (1 << COUNT_BITS) - 1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_PRD   = 10'b00_0000_0100,
        S_MOD   = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_SRD   = 10'b00_0010_0000,
        S_SCHK  = 10'b00_0100_0000,
        S_ORD   = 10'b00_1000_0000,
        S_NWR   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    function automatic logic [SAW-1:0] site_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
        return SAW'(int'(y) * GRID_X + int'(x));
    endfunction

    state_t                              state_reg, state_next;
    logic [lrtps_pkg::WIDTH_W-1:0]       lw_reg;
    logic [lrtps_pkg::HEIGHT_W-1:0]      lh_reg;
    logic [lrtps_pkg::OCC_W-1:0]         occ_reg;
    logic [lrtps_pkg::THR_W-1:0]         thr_reg;
    logic [SAW-1:0]                      clr_reg, clr_next;
    lrtps_pkg::item_t                    it_reg, it_next;
    logic [XW-1:0]                       ox_reg, ox_next;
    logic [YW-1:0]                       oy_reg, oy_next;
    logic [lrtps_pkg::DIR_W-1:0]         od_reg, od_next;
    logic [DW-1:0]                       dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic [DW-1:0]                       rmx_reg, rmx_next, rmy_reg, rmy_next;
    logic [CW-1:0]                       dcnt_reg, dcnt_next;
    logic [XW-1:0]                       nx_reg, nx_next;
    logic [YW-1:0]                       ny_reg, ny_next;
    logic [SAW-1:0]                      sa_reg, sa_next;
    logic [COUNT_BITS-1:0]               csn_reg, csn_next;
    logic                                mv_reg, mv_next;
    logic [lrtps_pkg::OUT_DATA_W-1:0]    res_reg, res_next;
    logic [lrtps_pkg::OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                                out_valid_reg, out_valid_next;

    logic [COUNT_BITS-1:0]               cnt_mem [NSITES];
    logic                                cnt_we, cnt_re;
    logic [SAW-1:0]                      cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]               cnt_wdata, cnt_rdata_reg;
    logic [PRW-1:0]                      part_mem [MAX_PARTICLES];
    logic                                part_we, part_re;
    logic [PW-1:0]                       part_waddr, part_raddr;
    logic [PRW-1:0]                      part_wdata, part_rdata_reg;

    logic [lrtps_pkg::WIDTH_W-1:0]       w;
    logic [lrtps_pkg::HEIGHT_W-1:0]      h;
    logic [COUNT_BITS-1:0]               lim;
    logic [DW-1:0]                       wx, hy;
    logic [DW:0]                         two_w, two_h;
    logic                                fast;
    logic [DW-1:0]                       rx, ry, tx, ty;
    lrtps_pkg::item_t                    in_item;
    logic                                in_acc, pidx_ok, is_upd, tumble;
    logic [SAW-1:0]                      osite;
    logic [COUNT_BITS-1:0]               c_now, c_new;
    logic [lrtps_pkg::DIR_W-1:0]         hd;
    logic [XW-1:0]                       fx;
    logic [YW-1:0]                       fy;

    always_comb
    begin
        if (lw_reg < 7'd2)
            w = 7'd2;
        else if (int'(lw_reg) > GRID_X)
            w = lrtps_pkg::WIDTH_W'(GRID_X);
        else
            w = lw_reg;
        if (lh_reg < 6'd2)
            h = 6'd2;
        else if (int'(lh_reg) > GRID_Y)
            h = lrtps_pkg::HEIGHT_W'(GRID_Y);
        else
            h = lh_reg;
        if (int'(occ_reg) < CMAX)
            lim = COUNT_BITS'(occ_reg);
        else
            lim = COUNT_BITS'(CMAX);
    end

    assign wx    = DW'(w);
    assign hy    = DW'(h);
    assign two_w = {wx, 1'b0};
    assign two_h = {hy, 1'b0};
    assign fast  = ({1'b0, dvx_reg} < two_w) && ({1'b0, dvy_reg} < two_h);
    assign rx    = (dvx_reg >= wx) ? (dvx_reg - wx) : dvx_reg;
    assign ry    = (dvy_reg >= hy) ? (dvy_reg - hy) : dvy_reg;

    always_comb
    begin
        tx = {rmx_reg[DW-2:0], dvx_reg[DW-1]};
        if (tx >= wx)
            tx = tx - wx;
        ty = {rmy_reg[DW-2:0], dvy_reg[DW-1]};
        if (ty >= hy)
            ty = ty - hy;
    end

    assign in_item = '{func: s_axis_tuser,
                       pidx: s_axis_tdata[11:0],
                       sx:   s_axis_tdata[17:12],
                       sy:   s_axis_tdata[22:18],
                       sdir: s_axis_tdata[24:23],
                       draw: s_axis_tdata[40:25],
                       ndir: s_axis_tdata[42:41]};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pidx_ok       = int'(in_item.pidx) < MAX_PARTICLES;
    assign is_upd        = (it_reg.func == lrtps_pkg::FN_UPDATE);
    assign osite         = site_addr(ox_reg, oy_reg);
    assign c_now         = cnt_rdata_reg;
    assign c_new         = mv_reg ? (csn_reg + 1'b1) : csn_reg;
    assign tumble        = ({1'b0, it_reg.draw} < thr_reg);
    assign hd            = tumble ? it_reg.ndir : od_reg;
    assign fx            = mv_reg ? nx_reg : ox_reg;
    assign fy            = mv_reg ? ny_reg : oy_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        it_next        = it_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        od_next        = od_reg;
        dvx_next       = dvx_reg;
        dvy_next       = dvy_reg;
        rmx_next       = rmx_reg;
        rmy_next       = rmy_reg;
        dcnt_next      = dcnt_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        sa_next        = sa_reg;
        csn_next       = csn_reg;
        mv_next        = mv_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        cnt_we         = 1'b0;
        cnt_waddr      = sa_reg;
        cnt_wdata      = '0;
        cnt_re         = 1'b0;
        cnt_raddr      = osite;
        part_we        = 1'b0;
        part_waddr     = PW'(it_reg.pidx);
        part_wdata     = '0;
        part_re        = 1'b0;
        part_raddr     = PW'(in_item.pidx);

        case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SAW'(NSITES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    it_next  = in_item;
                    dvx_next = DW'(in_item.sx);
                    dvy_next = DW'(in_item.sy);
                    res_next = lrtps_pkg::pack_result(in_item.pidx, '0, '0, '0,
                                                      1'b0, 1'b0, '0, 1'b0);
                    case (in_item.func)
                        lrtps_pkg::FN_READ:
                            state_next = S_MOD;
                        lrtps_pkg::FN_PLACE:
                            state_next = pidx_ok ? S_MOD : S_OUT;
                        lrtps_pkg::FN_UPDATE:
                        begin
                            part_re    = pidx_ok;
                            state_next = pidx_ok ? S_PRD : S_OUT;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_PRD:
            begin
                ox_next  = part_rdata_reg[YW + lrtps_pkg::DIR_W +: XW];
                oy_next  = part_rdata_reg[lrtps_pkg::DIR_W +: YW];
                od_next  = part_rdata_reg[lrtps_pkg::DIR_W-1:0];
                dvx_next = '0;
                dvy_next = '0;
                case (od_next)
                    lrtps_pkg::DIR_PX: dvx_next = DW'(ox_next) + DW'(1);
                    lrtps_pkg::DIR_PY: dvy_next = DW'(oy_next) + DW'(1);
                    lrtps_pkg::DIR_MX: dvx_next = DW'(ox_next) + wx - DW'(1);
                    lrtps_pkg::DIR_MY: dvy_next = DW'(oy_next) + hy - DW'(1);
                    default: ;
                endcase
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (fast)
                begin
                    nx_next    = (is_upd && od_reg[0]) ? ox_reg : XW'(rx);
                    ny_next    = (is_upd && !od_reg[0]) ? oy_reg : YW'(ry);
                    state_next = S_SRD;
                end
                else
                begin
                    rmx_next   = '0;
                    rmy_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rmx_next  = tx;
                rmy_next  = ty;
                dvx_next  = dvx_reg << 1;
                dvy_next  = dvy_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == CW'(DW - 1))
                begin
                    nx_next    = (is_upd && od_reg[0]) ? ox_reg : XW'(tx);
                    ny_next    = (is_upd && !od_reg[0]) ? oy_reg : YW'(ty);
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                sa_next    = site_addr(nx_reg, ny_reg);
                cnt_re     = 1'b1;
                cnt_raddr  = sa_next;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                csn_next = c_now;
                mv_next  = (c_now < lim);
                case (it_reg.func)
                    lrtps_pkg::FN_PLACE:
                    begin
                        if (c_now < lim)
                        begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = c_now + 1'b1;
                            part_we    = 1'b1;
                            part_wdata = {nx_reg, ny_reg, it_reg.sdir};
                        end
                        res_next = lrtps_pkg::pack_result(it_reg.pidx,
                            lrtps_pkg::SX_W'(nx_reg), lrtps_pkg::SY_W'(ny_reg),
                            it_reg.sdir, 1'b0, 1'b0,
                            lrtps_pkg::CNT_OUT_W'((c_now < lim) ? (c_now + 1'b1) : c_now),
                            !(c_now < lim));
                        state_next = S_OUT;
                    end
                    lrtps_pkg::FN_UPDATE:
                    begin
                        cnt_re     = 1'b1;
                        state_next = S_ORD;
                    end
                    default:
                    begin
                        res_next = lrtps_pkg::pack_result(it_reg.pidx,
                            lrtps_pkg::SX_W'(nx_reg), lrtps_pkg::SY_W'(ny_reg),
                            '0, 1'b0, 1'b0, lrtps_pkg::CNT_OUT_W'(c_now), 1'b0);
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ORD:
            begin
                if (mv_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = osite;
                    cnt_wdata = (c_now != '0) ? (c_now - 1'b1) : '0;
                end
                state_next = S_NWR;
            end
            S_NWR:
            begin
                if (mv_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = c_new;
                end
                if (mv_reg || tumble)
                begin
                    part_we    = 1'b1;
                    part_wdata = {fx, fy, hd};
                end
                res_next = lrtps_pkg::pack_result(it_reg.pidx,
                    lrtps_pkg::SX_W'(fx), lrtps_pkg::SY_W'(fy), hd, mv_reg, tumble,
                    lrtps_pkg::CNT_OUT_W'(c_new), 1'b0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            lw_reg        <= lrtps_pkg::RST_WIDTH;
            lh_reg        <= lrtps_pkg::RST_HEIGHT;
            occ_reg       <= lrtps_pkg::RST_OCC;
            thr_reg       <= lrtps_pkg::RST_THR;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lrtps_pkg::CFG_WIDTH:  lw_reg  <= cfg_data[lrtps_pkg::WIDTH_W-1:0];
                    lrtps_pkg::CFG_HEIGHT: lh_reg  <= cfg_data[lrtps_pkg::HEIGHT_W-1:0];
                    lrtps_pkg::CFG_OCC:    occ_reg <= cfg_data[lrtps_pkg::OCC_W-1:0];
                    lrtps_pkg::CFG_THR:    thr_reg <= cfg_data[lrtps_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg       <= it_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        od_reg       <= od_next;
        dvx_reg      <= dvx_next;
        dvy_reg      <= dvy_next;
        rmx_reg      <= rmx_next;
        rmy_reg      <= rmy_next;
        dcnt_reg     <= dcnt_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        sa_reg       <= sa_next;
        csn_reg      <= csn_next;
        mv_reg       <= mv_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (part_we)
            part_mem[part_waddr] <= part_wdata;
        if (part_re)
            part_rdata_reg <= part_mem[part_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // one word in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("word accepted while previous word still in work");

    // an increment never pushes a site past the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_we && (state_reg == S_SCHK || state_reg == S_NWR)) |-> (cnt_wdata <= lim))
        else $error("site count written above limit");

    // a waiting result is never overwritten by the next one
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_axis_tready) |=> (state_reg == S_OUT))
        else $error("result register loaded while occupied");

endmodule
